// ===== hw/rtl/mexp_pkg.sv =====
// Shared definitions for the modular exponentiation core.
// Holds the operand width, datapath operation codes and the command and
// status structures between the controller and the datapath. No dependencies.
`default_nettype none

package mexp_pkg;

    localparam int WIDTH = 32;
    localparam int IDX_W = $clog2(WIDTH);

    localparam logic [2:0] OP_NOP        = 3'd0;
    localparam logic [2:0] OP_LOAD       = 3'd1;
    localparam logic [2:0] OP_DBL        = 3'd2;
    localparam logic [2:0] OP_RED_ADD    = 3'd3;
    localparam logic [2:0] OP_MUL_ADD    = 3'd4;
    localparam logic [2:0] OP_COMMIT_RED = 3'd5;
    localparam logic [2:0] OP_COMMIT_MUL = 3'd6;
    localparam logic [2:0] OP_OUT        = 3'd7;

    typedef struct packed {
        logic [2:0]       op;
        logic [IDX_W-1:0] idx;
        logic             one;
    } t_dp_cmd;

    typedef struct packed {
        logic exp_zero;
        logic exp_upper_zero;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== hw/rtl/mexp_dp.sv =====
// Datapath of the modular exponentiation core: modulus register, operand
// registers and two shift-add modular multipliers that run side by side.
// Depends on mexp_pkg for the width, operation codes and command structures.
`default_nettype none

module mexp_dp (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [mexp_pkg::WIDTH-1:0] i_cfg_data,
    input  wire logic [mexp_pkg::WIDTH-1:0] i_base,
    input  wire logic [mexp_pkg::WIDTH-1:0] i_exponent,
    input  wire mexp_pkg::t_dp_cmd       i_cmd,
    output mexp_pkg::t_dp_sts            o_sts,
    output logic [mexp_pkg::WIDTH-1:0]   o_power
);

    localparam int W = mexp_pkg::WIDTH;

    logic [W-1:0] r_modulus;
    logic [W-1:0] r_base;
    logic [W-1:0] r_exp;
    logic [W-1:0] r_res;
    logic [W-1:0] r_acc_s;
    logic [W-1:0] r_acc_m;
    logic [W-1:0] r_power;

    logic [W-1:0] n_acc_s;
    logic [W-1:0] n_acc_m;
    logic [W-1:0] s_addend;
    logic         s_bit;

    // Adds two residues below the modulus; a zero modulus stands for 2^W.
    function automatic logic [W-1:0] add_mod(input logic [W-1:0] a,
                                             input logic [W-1:0] b,
                                             input logic [W-1:0] m);
        logic [W:0] sum;
        logic [W:0] diff;
        sum  = {1'b0, a} + {1'b0, b};
        diff = sum - {1'b0, m};
        if (m == '0) begin
            return sum[W-1:0];
        end else if (sum >= {1'b0, m}) begin
            return diff[W-1:0];
        end
        return sum[W-1:0];
    endfunction

    assign s_bit = r_base[i_cmd.idx];

    always_comb begin
        s_addend = r_base;
        n_acc_s  = r_acc_s;
        n_acc_m  = r_acc_m;
        case (i_cmd.op)
            mexp_pkg::OP_DBL: begin
                n_acc_s = add_mod(r_acc_s, r_acc_s, r_modulus);
                n_acc_m = add_mod(r_acc_m, r_acc_m, r_modulus);
            end
            mexp_pkg::OP_RED_ADD: begin
                s_addend = {{(W-1){1'b0}}, s_bit};
                n_acc_s  = add_mod(r_acc_s, s_addend, r_modulus);
            end
            mexp_pkg::OP_MUL_ADD: begin
                if (s_bit) begin
                    n_acc_s = add_mod(r_acc_s, s_addend, r_modulus);
                    n_acc_m = add_mod(r_acc_m, r_res, r_modulus);
                end
            end
            default: begin
                n_acc_s = r_acc_s;
                n_acc_m = r_acc_m;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= W'(1);
        end else if (i_cfg_we) begin
            r_modulus <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            mexp_pkg::OP_LOAD: begin
                r_base  <= i_base;
                r_exp   <= i_exponent;
                r_res   <= (r_modulus == W'(1)) ? '0 : W'(1);
                r_acc_s <= '0;
                r_acc_m <= '0;
            end
            mexp_pkg::OP_DBL, mexp_pkg::OP_RED_ADD, mexp_pkg::OP_MUL_ADD: begin
                r_acc_s <= n_acc_s;
                r_acc_m <= n_acc_m;
            end
            mexp_pkg::OP_COMMIT_RED: begin
                r_base  <= r_acc_s;
                r_acc_s <= '0;
                r_acc_m <= '0;
            end
            mexp_pkg::OP_COMMIT_MUL: begin
                if (r_exp[0]) begin
                    r_res <= r_acc_m;
                end
                r_base  <= r_acc_s;
                r_exp   <= {1'b0, r_exp[W-1:1]};
                r_acc_s <= '0;
                r_acc_m <= '0;
            end
            mexp_pkg::OP_OUT: begin
                r_power <= i_cmd.one ? W'(1) : r_res;
            end
            default: begin
                r_acc_s <= r_acc_s;
            end
        endcase
    end

    assign o_sts.exp_zero       = (r_exp == '0);
    assign o_sts.exp_upper_zero = (r_exp[W-1:1] == '0);
    assign o_power              = r_power;

endmodule

`default_nettype wire

// ===== hw/rtl/mexp_ctrl.sv =====
// Controller of the modular exponentiation core: handshakes, bit counter and
// the state machine that sequences the datapath one operation per cycle while
// the output is free. Depends on mexp_pkg for width, op codes and command types.
`default_nettype none

module mexp_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    output logic                   o_valid,
    input  wire logic              i_stall,
    input  wire mexp_pkg::t_dp_sts i_sts,
    output mexp_pkg::t_dp_cmd      o_cmd
);

    localparam int IW = mexp_pkg::IDX_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RED  = 3'd1;
    localparam logic [2:0] S_RCMT = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_MCMT = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    localparam logic [IW-1:0] TOP_BIT = IW'(mexp_pkg::WIDTH - 1);

    logic [2:0]    r_state, n_state;
    logic [IW-1:0] r_bit, n_bit;
    logic          r_phase, n_phase;
    logic          r_one, n_one;
    logic          r_out_valid, n_out_valid;
    logic          s_out_free;

    assign s_out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state     = r_state;
        n_bit       = r_bit;
        n_phase     = r_phase;
        n_one       = r_one;
        n_out_valid = r_out_valid && i_stall;
        o_cmd.op    = mexp_pkg::OP_NOP;
        o_cmd.idx   = r_bit;
        o_cmd.one   = r_one;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = mexp_pkg::OP_LOAD;
                    n_state  = S_RED;
                    n_bit    = TOP_BIT;
                    n_phase  = 1'b0;
                end
            end
            S_RED, S_MUL: begin
                if (!r_phase) begin
                    o_cmd.op = mexp_pkg::OP_DBL;
                end else if (r_state == S_RED) begin
                    o_cmd.op = mexp_pkg::OP_RED_ADD;
                end else begin
                    o_cmd.op = mexp_pkg::OP_MUL_ADD;
                end
                n_phase = !r_phase;
                if (r_phase) begin
                    if (r_bit == '0) begin
                        n_state = (r_state == S_RED) ? S_RCMT : S_MCMT;
                    end else begin
                        n_bit = r_bit - IW'(1);
                    end
                end
            end
            S_RCMT: begin
                o_cmd.op = mexp_pkg::OP_COMMIT_RED;
                n_bit    = TOP_BIT;
                n_phase  = 1'b0;
                n_one    = i_sts.exp_zero;
                n_state  = i_sts.exp_zero ? S_FIN : S_MUL;
            end
            S_MCMT: begin
                o_cmd.op = mexp_pkg::OP_COMMIT_MUL;
                n_bit    = TOP_BIT;
                n_phase  = 1'b0;
                n_state  = i_sts.exp_upper_zero ? S_FIN : S_MUL;
            end
            S_FIN: begin
                if (s_out_free) begin
                    o_cmd.op    = mexp_pkg::OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bit       <= '0;
            r_phase     <= 1'b0;
            r_one       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bit       <= n_bit;
            r_phase     <= n_phase;
            r_one       <= n_one;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== hw/rtl/modular_exponentiation_core.sv =====
// Top level of the modular exponentiation core: joins controller and datapath.
// Depends on mexp_pkg, mexp_ctrl and mexp_dp.
//
// Each input word carries a base and an exponent; the core returns one word
// holding base to the power exponent modulo the configured modulus. An
// exponent of zero gives 1. A modulus of zero means 2^32.
// The modulus is written through the configuration channel, which is always
// ready; write it only while no word is in flight. Reset sets it to 1.
// Input and output channels use valid and stall. The base is first reduced,
// then each exponent bit up to the highest set one is handled, with the
// square and the multiply running side by side in two shift-add units that
// take a doubling step and an add step per multiplier bit. The core takes
// one word at a time.
// A finished result waits in an output register while the receiver stalls,
// and the next input word is already accepted meanwhile; a further result
// holds back until that register is taken. Reset clears all control state.
`default_nettype none

module modular_exponentiation_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [mexp_pkg::WIDTH-1:0] i_cfg_data,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [mexp_pkg::WIDTH-1:0] i_base,
    input  wire logic [mexp_pkg::WIDTH-1:0] i_exponent,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [mexp_pkg::WIDTH-1:0]      o_power
);

    mexp_pkg::t_dp_cmd s_cmd;
    mexp_pkg::t_dp_sts s_sts;

    assign o_cfg_ready = 1'b1;

    mexp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (s_sts),
        .o_cmd   (s_cmd)
    );

    mexp_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_base     (i_base),
        .i_exponent (i_exponent),
        .i_cmd      (s_cmd),
        .o_sts      (s_sts),
        .o_power    (o_power)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/mexp_checker.sv =====
// Port-level checks for the modular exponentiation core, bound to the top.
// Depends on mexp_pkg for the operand width.
`default_nettype none

module mexp_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_valid,
    input wire logic                       o_stall,
    input wire logic                       o_valid,
    input wire logic                       i_stall,
    input wire logic [mexp_pkg::WIDTH-1:0] o_power
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_power))
        else $error("Stalled output word changed.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("Input still open after accepting a word.");

    a_result_at_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_stall) |-> o_valid)
        else $error("Core went idle without presenting a result.");

    a_new_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !o_stall)
        else $error("Result appeared while the core was busy.");

endmodule

bind modular_exponentiation_core mexp_checker u_mexp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_power (o_power)
);

`default_nettype wire
